// ----- hw/rtl/lobm_pkg.sv -----
// Shared types and constants for the limit order book matcher.
// No dependencies; used by the controller, datapath and top level.
package lobm_pkg;

  localparam logic [1:0] OP_LIMIT  = 2'd0;
  localparam logic [1:0] OP_MARKET = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_MODIFIED  = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;
  localparam logic [2:0] ST_DROPPED   = 3'd7;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input word
    logic fill;        // execute one fill against the best slot
    logic rest;        // rest the remainder in the free slot
    logic remove;      // invalidate the found slot
    logic modify;      // update quantity of the found slot in place
    logic unrest_side; // take the stored side of the found slot for re-add
  } lobm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] opcode;
    logic       zero_qty;
    logic       zero_price;
    logic       qty_done;
    logic       can_fill;
    logic       free_found;
    logic       id_found;
    logic       in_place;
  } lobm_sts_t;

endpackage

// ----- hw/rtl/lobm_datapath.sv -----
// Datapath of the order book matcher: slot table, best-entry search and fills.
// Depends on lobm_pkg.
module lobm_datapath
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_opcode,
  input  logic [31:0]      in_order_id,
  input  logic             in_side,
  input  logic [31:0]      in_price,
  input  logic [31:0]      in_quantity,
  input  lobm_cmd_t        cmd,
  output lobm_sts_t        sts,
  output logic [31:0]      trade_id,
  output logic [31:0]      resting_id,
  output logic [31:0]      aggressor_id,
  output logic [31:0]      trade_price,
  output logic [31:0]      trade_quantity
);

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int NP = 1 << IW;

  logic [ORDER_SLOTS-1:0] valid_r;
  logic                   side_r  [ORDER_SLOTS];
  logic [31:0]            price_r [ORDER_SLOTS];
  logic [31:0]            qty_r   [ORDER_SLOTS];
  logic [31:0]            id_r    [ORDER_SLOTS];
  logic [47:0]            stamp_r [ORDER_SLOTS];
  logic [47:0]            arrival_r;
  logic [31:0]            trade_cnt_r;

  logic [1:0]  op_r;
  logic [31:0] cid_r;
  logic        cside_r;
  logic [31:0] cprice_r;
  logic [31:0] cqty_r;

  // Best opposite entry: a tree search over the slots.
  logic          best_ok;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] free_idx;
  logic          free_ok;
  logic [IW-1:0] fid_idx;
  logic          fid_ok;
  logic [31:0]   traded;

  // Tree nodes in heap order: node 1 is the root, leaves start at NP.
  logic          node_ok    [2*NP];
  logic [IW-1:0] node_idx   [2*NP];
  logic [31:0]   node_price [2*NP];
  logic [47:0]   node_stamp [2*NP];

  // Returns 1 when slot a ranks before slot b for an aggressor on side sd.
  function automatic logic better(input logic sd, input logic [31:0] pa,
                                  input logic [47:0] sa, input logic [31:0] pb,
                                  input logic [47:0] sb);
    logic r;
    if (pa != pb) begin
      r = sd ? (pa > pb) : (pa < pb);
    end else begin
      r = sa < sb;
    end
    return r;
  endfunction

  // Pairwise reduction; the lower-index side wins unless the other ranks strictly better.
  always_comb begin
    for (int n = 0; n < 2*NP; n++) begin
      node_ok[n]    = 1'b0;
      node_idx[n]   = '0;
      node_price[n] = '0;
      node_stamp[n] = '0;
    end
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      node_ok[NP+i]    = valid_r[i] && (side_r[i] != cside_r);
      node_idx[NP+i]   = IW'(i);
      node_price[NP+i] = price_r[i];
      node_stamp[NP+i] = stamp_r[i];
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (node_ok[2*n+1] && (!node_ok[2*n] ||
          better(cside_r, node_price[2*n+1], node_stamp[2*n+1],
                 node_price[2*n], node_stamp[2*n]))) begin
        node_ok[n]    = 1'b1;
        node_idx[n]   = node_idx[2*n+1];
        node_price[n] = node_price[2*n+1];
        node_stamp[n] = node_stamp[2*n+1];
      end else begin
        node_ok[n]    = node_ok[2*n];
        node_idx[n]   = node_idx[2*n];
        node_price[n] = node_price[2*n];
        node_stamp[n] = node_stamp[2*n];
      end
    end
    best_ok  = node_ok[1];
    best_idx = node_idx[1];
  end

  // Lowest free slot and lowest slot holding the command's id.
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    fid_ok   = 1'b0;
    fid_idx  = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
      if (valid_r[i] && id_r[i] == cid_r) begin
        fid_ok  = 1'b1;
        fid_idx = IW'(i);
      end
    end
  end

  assign traded = (cqty_r < qty_r[best_idx]) ? cqty_r : qty_r[best_idx];

  // Status toward the controller.
  always_comb begin
    sts.opcode     = op_r;
    sts.zero_qty   = (cqty_r == 32'd0);
    sts.zero_price = (cprice_r == 32'd0);
    sts.qty_done   = (cqty_r == 32'd0);
    sts.can_fill   = best_ok && (op_r == OP_MARKET ||
                     (cside_r ? (cprice_r <= price_r[best_idx])
                              : (cprice_r >= price_r[best_idx])));
    sts.free_found = free_ok;
    sts.id_found   = fid_ok;
    sts.in_place   = (cprice_r == price_r[fid_idx]) && (cqty_r <= qty_r[fid_idx]);
  end

  // Trade word fields for the current fill.
  assign trade_id       = trade_cnt_r;
  assign resting_id     = id_r[best_idx];
  assign aggressor_id   = cid_r;
  assign trade_price    = price_r[best_idx];
  assign trade_quantity = traded;

  // Command word and table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      arrival_r   <= '0;
      trade_cnt_r <= 32'd1;
    end else begin
      if (cmd.load) begin
        op_r     <= in_opcode;
        cid_r    <= in_order_id;
        cside_r  <= in_side;
        cprice_r <= in_price;
        cqty_r   <= in_quantity;
      end
      if (cmd.unrest_side) begin
        cside_r <= side_r[fid_idx];
      end
      if (cmd.fill) begin
        cqty_r             <= cqty_r - traded;
        qty_r[best_idx]    <= qty_r[best_idx] - traded;
        trade_cnt_r        <= trade_cnt_r + 32'd1;
        if (qty_r[best_idx] == traded) begin
          valid_r[best_idx] <= 1'b0;
        end
      end
      if (cmd.remove) begin
        valid_r[fid_idx] <= 1'b0;
      end
      if (cmd.modify) begin
        qty_r[fid_idx] <= cqty_r;
      end
      if (cmd.rest) begin
        valid_r[free_idx]  <= 1'b1;
        side_r[free_idx]   <= cside_r;
        price_r[free_idx]  <= cprice_r;
        qty_r[free_idx]    <= cqty_r;
        id_r[free_idx]     <= cid_r;
        stamp_r[free_idx]  <= arrival_r;
        arrival_r          <= arrival_r + 48'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/lobm_ctrl.sv -----
// Controller of the order book matcher: sequences one command and drives output.
// Depends on lobm_pkg.
module lobm_ctrl
  import lobm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      out_ready,
  output logic      emit_valid,
  output logic      emit_kind,
  output logic [2:0] emit_status,
  input  lobm_sts_t sts,
  output lobm_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SWAP, S_MATCH, S_STATUS} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state, commands and the word offered to the output stage.
  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    cmd         = '0;
    emit_valid  = 1'b0;
    emit_kind   = KIND_STATUS;
    emit_status = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.opcode)
          OP_LIMIT, OP_MARKET: begin
            if (sts.zero_qty || (sts.opcode == OP_LIMIT && sts.zero_price)) begin
              st_nxt    = ST_REJECTED;
              state_nxt = S_STATUS;
            end else begin
              state_nxt = S_MATCH;
            end
          end
          OP_CANCEL: begin
            if (sts.id_found) begin
              cmd.remove = 1'b1;
              st_nxt     = ST_CANCELLED;
            end else begin
              st_nxt = ST_NOTFOUND;
            end
            state_nxt = S_STATUS;
          end
          default: begin
            if (sts.zero_qty || sts.zero_price) begin
              st_nxt    = ST_REJECTED;
              state_nxt = S_STATUS;
            end else if (!sts.id_found) begin
              st_nxt    = ST_NOTFOUND;
              state_nxt = S_STATUS;
            end else if (sts.in_place) begin
              cmd.modify = 1'b1;
              st_nxt     = ST_MODIFIED;
              state_nxt  = S_STATUS;
            end else begin
              cmd.unrest_side = 1'b1;
              state_nxt       = S_SWAP;
            end
          end
        endcase
      end
      S_SWAP: begin
        // Old slot leaves after its side has been taken over.
        cmd.remove = 1'b1;
        state_nxt  = S_MATCH;
      end
      S_MATCH: begin
        if (sts.qty_done) begin
          st_nxt    = ST_FILLED;
          state_nxt = S_STATUS;
        end else if (sts.can_fill) begin
          emit_valid = 1'b1;
          emit_kind  = KIND_TRADE;
          if (out_ready) begin
            cmd.fill = 1'b1;
          end
        end else if (sts.opcode == OP_MARKET) begin
          st_nxt    = ST_DROPPED;
          state_nxt = S_STATUS;
        end else if (sts.free_found) begin
          cmd.rest  = 1'b1;
          st_nxt    = ST_RESTED;
          state_nxt = S_STATUS;
        end else begin
          st_nxt    = ST_FULL;
          state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        emit_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_RESTED;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// ----- hw/rtl/limit_order_book_matcher_unit.sv -----
// Top level of the price-time priority order book matcher.
// Depends on lobm_pkg, lobm_ctrl and lobm_datapath.
//
// Usage:
//   The in_ channel takes one command word (add limit, add market, cancel,
//   modify). The out_ channel returns a run of words for it: one trade word
//   per fill (kind 0), then one status word (kind 1) with out_tlast high.
//   One fill is found per cycle by a tree search over all slots, unless the
//   output stalls. A reject, a cancel or an in-place modify goes from decode
//   straight to its status word, an add passes through matching first, and a
//   modify that re-adds its order also passes a swap state before matching;
//   with ORDER_SLOTS fills the run is ORDER_SLOTS + 1 words.
//   Commands are handled one at a time: in_tready is high only between runs.
//   The output is a register stage; a stall on out_tready holds the current
//   word and pauses matching without losing state.
//   Reset empties the book, sets the arrival stamp to zero and the trade
//   number to one; no words are pending afterward.
module limit_order_book_matcher_unit
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], order_id[33:2], side[34], price[66:35], quantity[98:67]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // trade_id[31:0], resting_id[63:32], aggressor_id[95:64],
  // trade_price[127:96], trade_quantity[159:128], status[162:160]
  output logic [167:0] out_tdata,
  output logic         out_tuser,  // kind[0]
  output logic         out_tlast
);

  lobm_cmd_t   cmd;
  lobm_sts_t   sts;
  logic        emit_valid, emit_kind;
  logic [2:0]  emit_status;
  logic [31:0] trade_id, resting_id, aggressor_id, trade_price, trade_quantity;
  logic        slot_free;

  logic         out_valid_r;
  logic [167:0] out_data_r;
  logic         out_kind_r;

  assign slot_free = !out_valid_r || out_tready;

  lobm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_ready  (slot_free),
    .emit_valid (emit_valid),
    .emit_kind  (emit_kind),
    .emit_status(emit_status),
    .sts        (sts),
    .cmd        (cmd)
  );

  lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_tdata[1:0]),
    .in_order_id   (in_tdata[33:2]),
    .in_side       (in_tdata[34]),
    .in_price      (in_tdata[66:35]),
    .in_quantity   (in_tdata[98:67]),
    .cmd           (cmd),
    .sts           (sts),
    .trade_id      (trade_id),
    .resting_id    (resting_id),
    .aggressor_id  (aggressor_id),
    .trade_price   (trade_price),
    .trade_quantity(trade_quantity)
  );

  // Output register; a status word carries the aggressor id and zeros in the other trade fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit_valid;
      if (emit_valid) begin
        out_kind_r <= emit_kind;
        if (emit_kind == KIND_TRADE) begin
          out_data_r <= {5'd0, ST_RESTED, trade_quantity, trade_price,
                         aggressor_id, resting_id, trade_id};
        end else begin
          out_data_r <= {5'd0, emit_status, 32'd0, 32'd0, aggressor_id,
                         32'd0, 32'd0};
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_kind_r;

endmodule

// ----- bench/lobm_checker.sv -----
// Checker for the order book matcher: watches both stream channels, keeps its own book,
// predicts every trade and status word and compares them in order.
// Depends on lobm_pkg for opcode, status and kind codes.
`timescale 1ns / 1ps
module lobm_checker
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  localparam int EXP_DEPTH = 256;

  typedef struct {
    logic        kind;
    logic [31:0] trade_id;
    logic [31:0] resting_id;
    logic [31:0] aggressor_id;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [2:0]  status;
    logic        last;
  } book_word_t;

  // Ring of expected words; the pointers only grow.
  book_word_t  exp_mem[EXP_DEPTH];
  int          wr_ptr;
  int          rd_ptr;

  // Shadow copy of the order book.
  logic        bk_valid[ORDER_SLOTS];
  logic        bk_side[ORDER_SLOTS];
  logic [31:0] bk_price[ORDER_SLOTS];
  logic [31:0] bk_qty[ORDER_SLOTS];
  logic [31:0] bk_id[ORDER_SLOTS];
  logic [47:0] bk_stamp[ORDER_SLOTS];
  logic [47:0] next_stamp;
  logic [31:0] next_trade;

  assign pending = wr_ptr - rd_ptr;

  task automatic push_word(input logic kind, input logic [31:0] tid, input logic [31:0] rid,
                           input logic [31:0] aid, input logic [31:0] pr,
                           input logic [31:0] q, input logic [2:0] st);
    book_word_t w;
    w.kind = kind; w.trade_id = tid; w.resting_id = rid; w.aggressor_id = aid;
    w.price = pr; w.quantity = q; w.status = st; w.last = (kind == KIND_STATUS);
    exp_mem[wr_ptr % EXP_DEPTH] = w;
    wr_ptr++;
  endtask

  // Fill against the best opposite orders; leaves the remainder in qty.
  task automatic sweep_book(input logic sd, input logic [31:0] pr, input bit mkt,
                            input logic [31:0] aid, inout logic [31:0] qty);
    int best;
    logic [31:0] fill;
    bit stop;
    stop = 0;
    while (qty != 0 && !stop) begin
      best = -1;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (bk_valid[i] && bk_side[i] != sd) begin
          if (best < 0) best = i;
          else if (bk_price[i] != bk_price[best]) begin
            if (sd == 1'b0 ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
              best = i;
          end else if (bk_stamp[i] < bk_stamp[best]) best = i;
        end
      end
      if (best < 0) stop = 1;
      else if (!mkt && ((sd == 1'b0 && pr < bk_price[best]) ||
                        (sd == 1'b1 && pr > bk_price[best]))) stop = 1;
      else begin
        fill = qty < bk_qty[best] ? qty : bk_qty[best];
        qty -= fill;
        bk_qty[best] -= fill;
        push_word(KIND_TRADE, next_trade, bk_id[best], aid, bk_price[best], fill, ST_RESTED);
        next_trade++;
        if (bk_qty[best] == 0) bk_valid[best] = 0;
      end
    end
  endtask

  task automatic place_limit(input logic sd, input logic [31:0] pr, input logic [31:0] q,
                             input logic [31:0] aid, output logic [2:0] st);
    logic [31:0] rem;
    rem = q;
    sweep_book(sd, pr, 0, aid, rem);
    if (rem == 0) st = ST_FILLED;
    else begin
      st = ST_FULL;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (st == ST_FULL && !bk_valid[i]) begin
          bk_valid[i] = 1; bk_side[i] = sd; bk_price[i] = pr; bk_qty[i] = rem;
          bk_id[i] = aid; bk_stamp[i] = next_stamp;
          next_stamp++;
          st = ST_RESTED;
        end
      end
    end
  endtask

  function automatic int lookup_id(input logic [31:0] id);
    for (int i = 0; i < ORDER_SLOTS; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // Work out the whole run of words for one command.
  task automatic predict_command(input logic [103:0] d);
    logic [1:0]  op;
    logic [31:0] id, pr, q, rem;
    logic        sd;
    logic [2:0]  st;
    int          s;
    op = d[1:0]; id = d[33:2]; sd = d[34]; pr = d[66:35]; q = d[98:67];
    case (op)
      OP_LIMIT: begin
        if (q == 0 || pr == 0) st = ST_REJECTED;
        else place_limit(sd, pr, q, id, st);
      end
      OP_MARKET: begin
        if (q == 0) st = ST_REJECTED;
        else begin
          rem = q;
          sweep_book(sd, 32'd0, 1, id, rem);
          st = (rem == 0) ? ST_FILLED : ST_DROPPED;
        end
      end
      OP_CANCEL: begin
        s = lookup_id(id);
        if (s < 0) st = ST_NOTFOUND;
        else begin
          bk_valid[s] = 0;
          st = ST_CANCELLED;
        end
      end
      default: begin
        if (q == 0 || pr == 0) st = ST_REJECTED;
        else begin
          s = lookup_id(id);
          if (s < 0) st = ST_NOTFOUND;
          else if (pr == bk_price[s] && q <= bk_qty[s]) begin
            bk_qty[s] = q;
            st = ST_MODIFIED;
          end else begin
            bk_valid[s] = 0;
            place_limit(bk_side[s], pr, q, id, st);
          end
        end
      end
    endcase
    push_word(KIND_STATUS, 32'd0, 32'd0, id, 32'd0, 32'd0, st);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Predict on every accepted command word, compare every accepted result word.
  always @(posedge clk) begin
    book_word_t w;
    if (!rst_n) begin
      wr_ptr = 0;
      rd_ptr = 0;
      for (int i = 0; i < ORDER_SLOTS; i++) bk_valid[i] = 0;
      next_stamp = '0;
      next_trade = 32'd1;
    end else begin
      if (out_tvalid && out_tready) begin
        if (wr_ptr == rd_ptr) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          w = exp_mem[rd_ptr % EXP_DEPTH];
          rd_ptr++;
          compare_field("kind", w.kind, out_tuser);
          compare_field("trade_id", w.trade_id, out_tdata[31:0]);
          compare_field("resting_id", w.resting_id, out_tdata[63:32]);
          compare_field("aggressor_id", w.aggressor_id, out_tdata[95:64]);
          compare_field("trade_price", w.price, out_tdata[127:96]);
          compare_field("trade_quantity", w.quantity, out_tdata[159:128]);
          compare_field("status", w.status, out_tdata[162:160]);
          compare_field("last", w.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) predict_command(in_tdata);
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the order book matcher bench: clock, reset, command stimulus and output back-pressure.
// Depends on lobm_pkg, limit_order_book_matcher_unit and lobm_checker.
`timescale 1ns / 1ps
module testbench
  import lobm_pkg::*;
();

  localparam int SLOTS       = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 290;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  int           taken_words = 0;
  bit           dominant_side;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  limit_order_book_matcher_unit #(.ORDER_SLOTS(SLOTS)) i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  lobm_checker #(.ORDER_SLOTS(SLOTS)) i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .pending
  );

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one command word after a random gap and wait for its acceptance.
  task automatic send_command(input logic [1:0] op, input logic [31:0] id, input logic sd,
                              input logic [31:0] pr, input logic [31:0] q);
    int gap;
    gap = ((cycle_count % 3000) < 400) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {5'd0, q, pr, sd, id, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(lo, hi);
    else if (r < 91) return 32'd0;
    else if (r < 94) return 32'd1;
    else if (r < 97) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Receiver: random stalls per word, one long hold-off once the book has been busy.
  initial begin
    int gap;
    bit held;
    held = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ((cycle_count % 2500) < 300) ? 0 : $urandom_range(0, 4);
      if (!held && taken_words > 60) begin
        held = 1;
        gap = 500;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken_words++;
    end
  end

  // Command stimulus and final verdict.
  initial begin
    logic [1:0]  op;
    logic [31:0] id, pr, q;
    logic        sd;
    int          r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects, unknown ids, an empty market, then a small crossing book.
    send_command(OP_LIMIT, 32'd10, 1'b0, 32'd0, 32'd5);
    send_command(OP_LIMIT, 32'd11, 1'b1, 32'd50, 32'd0);
    send_command(OP_MARKET, 32'd12, 1'b0, 32'd0, 32'd0);
    send_command(OP_MODIFY, 32'd13, 1'b0, 32'd0, 32'd4);
    send_command(OP_MODIFY, 32'd13, 1'b0, 32'd4, 32'd0);
    send_command(OP_CANCEL, 32'd99, 1'b0, 32'd0, 32'd0);
    send_command(OP_MODIFY, 32'd99, 1'b1, 32'd5, 32'd5);
    send_command(OP_MARKET, 32'd14, 1'b0, 32'd7, 32'd3);
    send_command(OP_LIMIT, 32'd1, 1'b1, 32'd100, 32'd10);
    send_command(OP_LIMIT, 32'd2, 1'b1, 32'd100, 32'd5);
    send_command(OP_LIMIT, 32'd3, 1'b1, 32'd99, 32'd4);
    send_command(OP_LIMIT, 32'd4, 1'b0, 32'd98, 32'd3);
    send_command(OP_LIMIT, 32'd5, 1'b0, 32'd100, 32'd6);
    send_command(OP_MODIFY, 32'd1, 1'b0, 32'd100, 32'd5);
    send_command(OP_MODIFY, 32'd2, 1'b0, 32'd101, 32'd5);
    send_command(OP_MARKET, 32'd6, 1'b1, 32'd0, 32'hFFFF_FFFF);
    send_command(OP_LIMIT, 32'd7, 1'b0, 32'hFFFF_FFFF, 32'd1);
    send_command(OP_CANCEL, 32'd2, 1'b1, 32'd0, 32'd0);
    send_command(OP_CANCEL, 32'd2, 1'b0, 32'd0, 32'd0);
    send_command(OP_LIMIT, 32'd8, 1'b1, 32'd1, 32'hFFFF_FFFE);
    send_command(OP_MARKET, 32'd9, 1'b0, 32'hFFFF_FFFF, 32'd2);
    send_command(OP_MODIFY, 32'd8, 1'b1, 32'd1, 32'hFFFF_FFFF);
    send_command(OP_LIMIT, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_CANCEL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random: small id pool and near prices so orders meet, one side favored for a while
    // so that the book fills up.
    dominant_side = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) dominant_side = 1'($urandom_range(0, 1));
      if (n == 150) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r  = $urandom_range(0, 99);
      op = r < 50 ? OP_LIMIT : r < 65 ? OP_MARKET : r < 80 ? OP_CANCEL : OP_MODIFY;
      id = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 48);
      sd = ($urandom_range(0, 9) < 8) ? dominant_side : ~dominant_side;
      pr = sd ? pick_value(32'd100, 32'd110) : pick_value(32'd90, 32'd100);
      q  = pick_value(32'd1, 32'd20);
      send_command(op, id, sd, pr, q);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_datapath.sv
hw/rtl/lobm_ctrl.sv
hw/rtl/limit_order_book_matcher_unit.sv
bench/lobm_checker.sv
bench/testbench.sv
